// ----- src/fra_pkg.sv -----
// Package with shared types and constants for the running-average queue.
`timescale 1ns / 1ps

package fra_pkg;

   // Fixed field widths
   localparam int VALUE_W = 32;
   localparam int FRAC_W  = 8;
   localparam int MEAN_W  = 40;

   // Request codes
   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIVIDE,
      ST_DONE
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic div_start;
      logic div_step;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic div_done;
   } dp_stat_type;

endpackage

// ----- src/fifo_running_average.sv -----
// Top level of the queue with running count, sum and fixed-point mean.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   req     | in        | req_valid/req_ready  | req_type, req_value
//   rsp     | out       | rsp_valid/rsp_ready  | status, removed_value, count,
//           |           |                      | running_sum, mean_fixed, mean_valid
//
// One transaction at a time: accept, ring read, update, divider load, SUM_W+8
// divider steps (one quotient bit per cycle), a state to see them done, result load;
// the result load waits until the output register is free.
// Synchronous active-high reset clears count, sum and ring pointer; the ring
// memory itself is not cleared. A stalled response sits in the output register
// while the next request is taken and worked on up to the result load.
`timescale 1ns / 1ps

module fifo_running_average
   import fra_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int SUM_W = VALUE_W + $clog2(DEPTH)
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic signed [VALUE_W-1:0] rsp_removed_value,
   output logic [CNT_W-1:0]          rsp_count,
   output logic signed [SUM_W-1:0]   rsp_running_sum,
   output logic signed [MEAN_W-1:0]  rsp_mean_fixed,
   output logic                      rsp_mean_valid
);

   ctrl_cmd_type cmd;
   dp_stat_type  dp_stat;

   fra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   fra_dp #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_stat           (dp_stat),
      .req_type          (req_type),
      .req_value         (req_value),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count         (rsp_count),
      .rsp_running_sum   (rsp_running_sum),
      .rsp_mean_fixed    (rsp_mean_fixed),
      .rsp_mean_valid    (rsp_mean_valid)
   );

endmodule

// ----- src/fra_ctrl.sv -----
// Controller state machine sequencing one transaction through the datapath.
`timescale 1ns / 1ps

module fra_ctrl
   import fra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  dp_stat,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // Output register can take a new result
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_EXEC;
         ST_EXEC:      state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIVIDE;
         ST_DIVIDE:    if (dp_stat.div_done) state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC:      ;
         ST_UPDATE:    cmd.update = 1'b1;
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_DIVIDE:    cmd.div_step = !dp_stat.div_done;
         ST_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/fra_dp.sv -----
// Datapath: queue ring memory, count and sum, restoring divider, result registers.
`timescale 1ns / 1ps

module fra_dp
   import fra_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int IDX_W  = 4,
   parameter int CNT_W  = 5,
   parameter int SUM_W  = 36
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_stat_type              dp_stat,
   input  logic                     req_type,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic [1:0]               rsp_status,
   output logic signed [VALUE_W-1:0] rsp_removed_value,
   output logic [CNT_W-1:0]         rsp_count,
   output logic signed [SUM_W-1:0]  rsp_running_sum,
   output logic signed [MEAN_W-1:0] rsp_mean_fixed,
   output logic                     rsp_mean_valid
);

   localparam int DIVD_W = SUM_W + FRAC_W;
   localparam int STEP_W = $clog2(DIVD_W + 1);

   // Captured transaction
   logic                 type_ff;
   logic [VALUE_W-1:0]   value_ff;

   // Ring memory and its registered read port
   logic [VALUE_W-1:0]   mem [DEPTH];
   logic [VALUE_W-1:0]   rd_ff;

   // Queue state
   logic [IDX_W-1:0]     oldest_ff, oldest_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   status_type           status_ff, status_in;
   logic [VALUE_W-1:0]   removed_ff, removed_in;

   // Divider
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIVD_W-1:0]    quot_ff, quot_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 neg_ff, neg_in;

   // Response registers
   status_type           rsp_status_ff;
   logic [VALUE_W-1:0]   rsp_removed_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic [SUM_W-1:0]     rsp_sum_ff;
   logic [MEAN_W-1:0]    rsp_mean_ff;
   logic                 rsp_mean_valid_ff;

   logic                 full, empty, do_write;
   logic [IDX_W:0]       tail_w;
   logic [IDX_W-1:0]     tail;
   logic [SUM_W-1:0]     value_ext, rd_ext, sum_mag;
   logic [CNT_W:0]       trial;
   logic                 trial_ge;
   logic [MEAN_W-1:0]    quot_lo, mean_signed;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // Tail position: oldest plus count, wrapped once
   assign tail_w = (IDX_W+1)'(oldest_ff) + (IDX_W+1)'(count_ff);
   always_comb begin
      if (tail_w >= (IDX_W+1)'(DEPTH)) begin
         tail = IDX_W'(tail_w - (IDX_W+1)'(DEPTH));
      end else begin
         tail = tail_w[IDX_W-1:0];
      end
   end

   assign value_ext = {{(SUM_W-VALUE_W){value_ff[VALUE_W-1]}}, value_ff};
   assign rd_ext    = {{(SUM_W-VALUE_W){rd_ff[VALUE_W-1]}}, rd_ff};
   assign do_write  = cmd.update && (type_ff == REQ_ENQUEUE) && !full;

   // Queue bookkeeping
   always_comb begin
      oldest_in  = oldest_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      if (cmd.update) begin
         status_in  = STATUS_OK;
         removed_in = '0;
         if (type_ff == REQ_ENQUEUE) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               sum_in   = sum_ff + value_ext;
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               removed_in = rd_ff;
               count_in   = count_ff - 1'b1;
               sum_in     = sum_ff - rd_ext;
               if (oldest_ff == IDX_W'(DEPTH - 1)) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_ff + 1'b1;
               end
            end
         end
      end
   end

   // Restoring divider, one quotient bit per cycle
   assign sum_mag  = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign trial    = {rem_ff, quot_ff[DIVD_W-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      if (cmd.div_start) begin
         rem_in  = '0;
         quot_in = {sum_mag, {FRAC_W{1'b0}}};
         step_in = '0;
         neg_in  = sum_ff[SUM_W-1];
      end else if (cmd.div_step) begin
         if (trial_ge) begin
            rem_in = CNT_W'(trial - {1'b0, count_ff});
         end else begin
            rem_in = CNT_W'(trial);
         end
         quot_in = {quot_ff[DIVD_W-2:0], trial_ge};
         step_in = step_ff + 1'b1;
      end
   end

   assign dp_stat.div_done = (step_ff == STEP_W'(DIVD_W));

   // Quotient fits the mean width since the mean is bounded by one value
   assign quot_lo     = quot_ff[MEAN_W-1:0];
   assign mean_signed = neg_ff ? (~quot_lo + 1'b1) : quot_lo;

   // Queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         step_ff   <= '0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         step_ff   <= step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         value_ff <= req_value;
      end
      status_ff  <= status_in;
      removed_ff <= removed_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      neg_ff     <= neg_in;
      if (cmd.load_rsp) begin
         rsp_status_ff     <= status_ff;
         rsp_removed_ff    <= removed_ff;
         rsp_count_ff      <= count_ff;
         rsp_sum_ff        <= sum_ff;
         rsp_mean_valid_ff <= !empty;
         rsp_mean_ff       <= empty ? '0 : mean_signed;
      end
   end

   // Ring memory: write at tail, registered read at oldest
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[tail] <= value_ff;
      end
      rd_ff <= mem[oldest_ff];
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_running_sum   = rsp_sum_ff;
   assign rsp_mean_fixed    = rsp_mean_ff;
   assign rsp_mean_valid    = rsp_mean_valid_ff;

endmodule
